// File: rtl/fixed_point_alu_q24_8_defines.svh
// Assertion macros for the fixed-point ALU checker.
// Depends on nothing; the including module supplies clock and reset.
`ifndef FIXED_POINT_ALU_Q24_8_DEFINES_SVH
`define FIXED_POINT_ALU_Q24_8_DEFINES_SVH

// Checked only outside reset.
`define FPA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define FPA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/fpa_pkg.sv
// Shared types and constants of the fixed-point ALU.
// No dependencies.
package fpa_pkg;

   typedef enum logic [3:0] {
      CMD_ADD      = 4'd0,
      CMD_SUB      = 4'd1,
      CMD_MUL      = 4'd2,
      CMD_DIV      = 4'd3,
      CMD_GT       = 4'd4,
      CMD_LT       = 4'd5,
      CMD_GE       = 4'd6,
      CMD_LE       = 4'd7,
      CMD_EQ       = 4'd8,
      CMD_NE       = 4'd9,
      CMD_INC      = 4'd10,
      CMD_DEC      = 4'd11,
      CMD_MIN      = 4'd12,
      CMD_MAX      = 4'd13,
      CMD_FROM_INT = 4'd14,
      CMD_TO_INT   = 4'd15
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_DIV_ZERO = 2'd2
   } status_type;

   // quotient bits produced by the divider (bit 32 down to bit 0)
   localparam int DIV_STEPS = 33;

   localparam logic signed [31:0] RAW_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] RAW_MIN = 32'sh8000_0000;

   typedef struct packed {
      cmd_type            cmd;
      logic               neg;
      logic               div_ovf;
      logic               div_zero;
      logic signed [31:0] res;
      status_type         status;
      logic signed [63:0] prod;
      logic [31:0]        rem;
      logic [31:0]        den;
      logic [32:0]        lowq;
      logic [63:0]        mag;
   } stage_type;

   function automatic logic sat_flag(input logic signed [63:0] v);
      return (v > 64'(RAW_MAX)) || (v < 64'(RAW_MIN));
   endfunction

   function automatic logic signed [31:0] sat_value(input logic signed [63:0] v);
      if (v > 64'(RAW_MAX)) return RAW_MAX;
      if (v < 64'(RAW_MIN)) return RAW_MIN;
      return v[31:0];
   endfunction

endpackage

// File: rtl/fpa_req_if.sv
// Request channel: command and two operands.
// No dependencies.
interface fpa_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         cmd;
   logic signed [31:0] operand_a;
   logic signed [31:0] operand_b;

   modport source (output valid, cmd, operand_a, operand_b, input ready);
   modport sink (input valid, cmd, operand_a, operand_b, output ready);
   modport monitor (input valid, ready, cmd, operand_a, operand_b);
endinterface

// File: rtl/fpa_rsp_if.sv
// Response channel: result value and status.
// No dependencies.
interface fpa_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_value;
   logic [1:0]         status;

   modport source (output valid, result_value, status, input ready);
   modport sink (input valid, result_value, status, output ready);
   modport monitor (input valid, ready, result_value, status);
endinterface

// File: rtl/fpa_front.sv
// Entry stage: simple operations, the multiplier and divider setup.
// Depends on fpa_pkg.
module fpa_front #(
   parameter int FRACTION_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               valid_in,
   input  logic [3:0]         cmd_in,
   input  logic signed [31:0] a,
   input  logic signed [31:0] b,
   output logic               valid_ff,
   output fpa_pkg::stage_type stage_ff
);
   import fpa_pkg::*;

   stage_type          stage_in;
   logic signed [63:0] a64;
   logic signed [63:0] b64;
   logic signed [63:0] wide;
   logic [31:0]        mag_a;
   logic [31:0]        mag_b;
   logic [63:0]        num;

   always_comb begin
      a64   = 64'(a);
      b64   = 64'(b);
      mag_a = a[31] ? (~a + 32'd1) : a;
      mag_b = b[31] ? (~b + 32'd1) : b;
      num   = {32'd0, mag_a} << FRACTION_BITS;
      wide  = 64'sd0;

      stage_in          = '0;
      stage_in.cmd      = cmd_type'(cmd_in);
      stage_in.prod     = a64 * b64;
      stage_in.den      = mag_b;
      stage_in.rem      = {1'b0, num[63:33]};
      stage_in.lowq     = num[32:0];
      stage_in.div_ovf  = {1'b0, num[63:33]} >= mag_b;
      stage_in.div_zero = (b == 32'sd0);
      stage_in.neg      = a[31] ^ b[31];
      stage_in.status   = ST_OK;

      case (cmd_type'(cmd_in))
         CMD_ADD: wide = a64 + b64;
         CMD_SUB: wide = a64 - b64;
         CMD_INC: wide = a64 + 64'sd1;
         CMD_DEC: wide = a64 - 64'sd1;
         CMD_FROM_INT: wide = a64 <<< FRACTION_BITS;
         default: wide = 64'sd0;
      endcase

      case (cmd_type'(cmd_in))
         CMD_ADD, CMD_SUB, CMD_INC, CMD_DEC, CMD_FROM_INT: begin
            stage_in.res    = sat_value(wide);
            stage_in.status = sat_flag(wide) ? ST_OVERFLOW : ST_OK;
         end
         CMD_GT: stage_in.res = {31'd0, a > b};
         CMD_LT: stage_in.res = {31'd0, a < b};
         CMD_GE: stage_in.res = {31'd0, a >= b};
         CMD_LE: stage_in.res = {31'd0, a <= b};
         CMD_EQ: stage_in.res = {31'd0, a == b};
         CMD_NE: stage_in.res = {31'd0, a != b};
         CMD_MIN: stage_in.res = (a < b) ? a : b;
         CMD_MAX: stage_in.res = (a > b) ? a : b;
         CMD_TO_INT: stage_in.res = a >>> FRACTION_BITS;
         default: stage_in.res = 32'sd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

endmodule

// File: rtl/fpa_div_stage.sv
// One restoring-division step: one quotient bit per stage.
// Depends on fpa_pkg.
module fpa_div_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               valid_in,
   input  fpa_pkg::stage_type stage_in,
   output logic               valid_ff,
   output fpa_pkg::stage_type stage_ff
);
   import fpa_pkg::*;

   stage_type   stage_nx;
   logic [32:0] rem_sh;
   logic [33:0] trial;
   logic        ge;

   always_comb begin
      rem_sh   = {stage_in.rem, stage_in.lowq[32]};
      trial    = {1'b0, rem_sh} - {2'b00, stage_in.den};
      ge       = ~trial[33];
      stage_nx = stage_in;
      stage_nx.rem  = ge ? trial[31:0] : rem_sh[31:0];
      stage_nx.lowq = {stage_in.lowq[31:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_nx;
      end
   end

endmodule

// File: rtl/fpa_post.sv
// Rounding and saturation of multiply and divide, two register stages.
// Depends on fpa_pkg.
module fpa_post #(
   parameter int FRACTION_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               valid_in,
   input  fpa_pkg::stage_type stage_in,
   output logic               valid_ff,
   output logic signed [31:0] result_ff,
   output fpa_pkg::status_type status_ff
);
   import fpa_pkg::*;

   localparam logic [63:0] HALF = (64'd1 << FRACTION_BITS) >> 1;

   stage_type           mid_in;
   stage_type           mid_ff;
   logic                mid_valid_ff;
   logic [63:0]         pmag;
   logic                rnd;
   logic signed [31:0]  result_in;
   status_type          status_in;
   logic                ovf;

   // round magnitudes, half away from zero
   always_comb begin
      pmag   = stage_in.prod[63] ? (~stage_in.prod + 64'd1) : stage_in.prod;
      rnd    = {stage_in.rem, 1'b0} >= {1'b0, stage_in.den};
      mid_in = stage_in;
      if (stage_in.cmd == CMD_MUL) begin
         mid_in.mag = (pmag + HALF) >> FRACTION_BITS;
         mid_in.neg = stage_in.prod[63];
      end else begin
         mid_in.mag = 64'(stage_in.lowq) + 64'(rnd);
      end
   end

   // clamp and apply sign
   always_comb begin
      result_in = mid_ff.res;
      status_in = mid_ff.status;
      ovf = mid_ff.neg ? (mid_ff.mag > 64'h8000_0000) : (mid_ff.mag > 64'h7FFF_FFFF);
      case (mid_ff.cmd)
         CMD_MUL, CMD_DIV: begin
            if ((mid_ff.cmd == CMD_DIV) && mid_ff.div_zero) begin
               result_in = 32'sd0;
               status_in = ST_DIV_ZERO;
            end else if (ovf || ((mid_ff.cmd == CMD_DIV) && mid_ff.div_ovf)) begin
               result_in = mid_ff.neg ? RAW_MIN : RAW_MAX;
               status_in = ST_OVERFLOW;
            end else begin
               result_in = mid_ff.neg ? (~mid_ff.mag[31:0] + 32'd1) : mid_ff.mag[31:0];
               status_in = ST_OK;
            end
         end
         default: begin
            result_in = mid_ff.res;
            status_in = mid_ff.status;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else if (adv) begin
         mid_valid_ff <= valid_in;
         valid_ff     <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mid_ff    <= mid_in;
         result_ff <= result_in;
         status_ff <= status_in;
      end
   end

endmodule

// File: rtl/fpa_skid.sv
// Two-entry output queue; its fill level stalls the pipeline.
// Depends on fpa_pkg.
module fpa_skid (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic signed [31:0]  result_in,
   input  fpa_pkg::status_type status_in,
   input  logic                pop_ready,
   output logic                out_valid,
   output logic signed [31:0]  out_result,
   output logic [1:0]          out_status,
   output logic                full
);
   import fpa_pkg::*;

   logic signed [31:0] value_mem [0:1];
   status_type         status_mem [0:1];
   logic [1:0]         count_ff;
   logic               wr_ptr_ff;
   logic               rd_ptr_ff;
   logic               pop;

   assign full       = (count_ff == 2'd2);
   assign out_valid  = (count_ff != 2'd0);
   assign pop        = out_valid && pop_ready;
   assign out_result = value_mem[rd_ptr_ff];
   assign out_status = status_mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         value_mem[wr_ptr_ff]  <= result_in;
         status_mem[wr_ptr_ff] <= status_in;
      end
   end

endmodule

// File: rtl/fixed_point_alu_q24_8.sv
// Signed fixed-point ALU, 32-bit raw values with FRACTION_BITS fraction bits.
// Depends on fpa_pkg, fpa_req_if, fpa_rsp_if, fpa_front, fpa_div_stage,
// fpa_post and fpa_skid.
//
// One beat in, one beat out, in order. A new request can be taken every
// cycle while the output queue is not full; the pipeline is 36 register
// stages (entry, 33 divider steps, round, saturate) followed by a
// two-entry output queue. The 33-step restoring divider sets the depth;
// every command travels the same path so order is kept. The whole
// pipeline stalls only when the output queue is full, so one waiting
// response does not block the request side. Mul and div round half away
// from zero; add, sub, mul and div saturate and flag overflow; div by
// zero gives 0 with the divide-by-zero status.
module fixed_point_alu_q24_8 #(
   parameter int FRACTION_BITS = 8
) (
   input logic      clock,
   input logic      reset,
   fpa_req_if.sink   req_chan,
   fpa_rsp_if.source rsp_chan
);
   import fpa_pkg::*;

   // pipeline advance: held off only while the output queue is full
   logic adv;
   logic full;

   logic      vld [0:DIV_STEPS];
   stage_type stg [0:DIV_STEPS];

   logic               post_valid;
   logic signed [31:0] post_result;
   status_type         post_status;

   assign adv = ~full;
   assign req_chan.ready = adv;

   // entry: simple ops finish here, multiplier and divider are set up
   fpa_front #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .valid_in (req_chan.valid),
      .cmd_in   (req_chan.cmd),
      .a        (req_chan.operand_a),
      .b        (req_chan.operand_b),
      .valid_ff (vld[0]),
      .stage_ff (stg[0])
   );

   // one quotient bit per stage, MSB first
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      fpa_div_stage u_step (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .valid_in (vld[k]),
         .stage_in (stg[k]),
         .valid_ff (vld[k+1]),
         .stage_ff (stg[k+1])
      );
   end

   fpa_post #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_post (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .valid_in  (vld[DIV_STEPS]),
      .stage_in  (stg[DIV_STEPS]),
      .valid_ff  (post_valid),
      .result_ff (post_result),
      .status_ff (post_status)
   );

   // push only happens while not full, so no beat is dropped
   fpa_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push       (post_valid && adv),
      .result_in  (post_result),
      .status_in  (post_status),
      .pop_ready  (rsp_chan.ready),
      .out_valid  (rsp_chan.valid),
      .out_result (rsp_chan.result_value),
      .out_status (rsp_chan.status),
      .full       (full)
   );

endmodule

// File: rtl/fpa_checker.sv
// Port-level checks of the fixed-point ALU, bound to the top level.
// Depends on fpa_pkg and the defines header.
`include "fixed_point_alu_q24_8_defines.svh"

module fpa_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_value,
   input logic [1:0]         rsp_status
);
   import fpa_pkg::*;

   logic        rsp_stall;
   logic        rsp_pop;
   logic        rsp_dz;
   logic        rsp_ovf;
   logic        rsp_rail;
   logic [33:0] rsp_beat;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_pop   = rsp_valid && rsp_ready;
   assign rsp_dz    = rsp_valid && (rsp_status == ST_DIV_ZERO);
   assign rsp_ovf   = rsp_valid && (rsp_status == ST_OVERFLOW);
   assign rsp_rail  = (rsp_value == RAW_MAX) || (rsp_value == RAW_MIN);
   assign rsp_beat  = {rsp_value, rsp_status};

   `FPA_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "response after reset")
   `FPA_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_beat), "stalled beat changed")
   `FPA_ASSERT(a_dz_zero, rsp_dz |-> rsp_value == 32'sd0, "div by zero nonzero")
   `FPA_ASSERT(a_ovf_rail, rsp_ovf |-> rsp_rail, "overflow off rail")
   `FPA_ASSERT(a_req_ready, rsp_pop |=> req_ready, "no room after pop")

endmodule

bind fixed_point_alu_q24_8 fpa_checker u_fpa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_value  (rsp_chan.result_value),
   .rsp_status (rsp_chan.status)
);
